>>> hw/rtl/plg_pkg.sv
// shared types, register indexes and saturation helpers for the lorentzian line block
`timescale 1ns / 1ps
package plg_pkg;

    localparam int C_FRACTION_BITS = 16;

    localparam logic [7:0] C_REG_OFFSET = 8'd0;
    localparam logic [7:0] C_REG_SLOPE  = 8'd1;

    typedef struct packed {
        logic signed [31:0] x_position;
        logic signed [31:0] amplitude;
        logic signed [31:0] center;
        logic signed [31:0] width;
        logic signed [15:0] cos_phase;
        logic signed [15:0] sin_phase;
        logic               last_line;
    } t_in_item;

    typedef struct packed {
        logic signed [39:0] line_value;
        logic signed [39:0] d_amplitude;
        logic signed [39:0] d_center;
        logic signed [39:0] d_width;
        logic signed [39:0] d_phase;
        logic signed [47:0] total_value;
        logic               point_done;
    } t_out_item;

    localparam logic signed [69:0] C_MAX40 = 70'sd549755813887;
    localparam logic signed [69:0] C_MIN40 = -70'sd549755813888;
    localparam logic signed [69:0] C_MAX48 = 70'sd140737488355327;
    localparam logic signed [69:0] C_MIN48 = -70'sd140737488355328;

    function automatic logic signed [39:0] sat_40(input logic signed [69:0] v);
        logic signed [69:0] t;
        begin
            t = (v > C_MAX40) ? C_MAX40 : ((v < C_MIN40) ? C_MIN40 : v);
            return t[39:0];
        end
    endfunction

    function automatic logic signed [47:0] sat_48(input logic signed [69:0] v);
        logic signed [69:0] t;
        begin
            t = (v > C_MAX48) ? C_MAX48 : ((v < C_MIN48) ? C_MIN48 : v);
            return t[47:0];
        end
    endfunction

endpackage

>>> hw/rtl/phased_lorentzian_with_gradient.sv
// phased lorentzian line value, parameter gradient and point sum on one shared multiplier-divider
// sequence from input accept to result valid: 3 ratio divides of 30 steps,
//   2 quotient divides of 64 steps, 23 multiply and control steps on one 34x34 multiplier
// input is not ready while an item is in work, so no new item is taken before the last one is done;
//   a finished result waits in the output register while the next item is taken
// reset: synchronous active low, clears sequencer, baseline registers, running sum, point flag and output valid
`timescale 1ns / 1ps
module phased_lorentzian_with_gradient #(
    parameter int P_FRACTION_BITS = plg_pkg::C_FRACTION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  plg_pkg::t_in_item i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output plg_pkg::t_out_item o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import plg_pkg::*;

    localparam int L_SH_C = 28 - P_FRACTION_BITS;
    localparam int L_SH_W = 29 - P_FRACTION_BITS;
    localparam int L_SH_A = 29 - P_FRACTION_BITS;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PREP, ST_MUU, ST_MWW, ST_MUW, ST_SUM, ST_BASE,
        ST_DIV, ST_R, ST_Q, ST_T,
        ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
        ST_M10, ST_M11, ST_M12, ST_DC, ST_DW
    } t_state;

    t_state             r_state, r_ret;
    t_in_item           r_in;
    logic signed [31:0] r_offset, r_slope;
    logic signed [47:0] r_sum;
    logic               r_open;
    logic [30:0]        r_w, r_bu, r_bw;
    logic               r_uneg;
    logic [61:0]        r_uu, r_ww, r_uw;
    logic [63:0]        r_s;
    logic [30:0]        r_r, r_q;
    logic signed [33:0] r_t, r_a, r_b, r_g, r_rg, r_tg;
    logic signed [67:0] r_prod, r_acc;
    logic signed [39:0] r_yl, r_dp, r_dc;
    logic [63:0]        r_rem, r_dvd, r_quo, r_den;
    logic [6:0]         r_cnt;
    logic               r_full, r_neg;
    t_out_item          r_out;
    logic               r_out_valid;

    logic signed [33:0] w_op_a, w_op_b;
    logic signed [67:0] w_mul;
    logic signed [32:0] w_diff;
    logic signed [33:0] w_u;
    logic [33:0]        w_um, w_big, w_wz;
    logic [30:0]        w_wc;
    logic [1:0]         w_k;
    logic signed [33:0] w_c34, w_s34, w_2c, w_ns, w_qr;
    logic signed [67:0] w_pair, w_pair15, w_pair16, w_p29, w_pf;
    logic signed [69:0] w_bsum, w_rsum, w_qs;
    logic [64:0]        w_rem2;
    logic               w_ge;
    logic [30:0]        w_ratio;
    logic [63:0]        w_mag;
    logic signed [33:0] w_a_sh;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;

    // operand prep
    assign w_wc   = (r_in.width <= 32'sd0) ? 31'd1 : r_in.width[30:0];
    assign w_diff = {r_in.x_position[31], r_in.x_position} - {r_in.center[31], r_in.center};
    assign w_u    = {w_diff, 1'b0};
    assign w_um   = w_u[33] ? 34'(-w_u) : w_u;
    assign w_wz   = {3'b000, w_wc};
    assign w_big  = (w_um > w_wz) ? w_um : w_wz;
    assign w_k    = w_big[33] ? 2'd3 : (w_big[32] ? 2'd2 : (w_big[31] ? 2'd1 : 2'd0));

    assign w_c34 = {{18{r_in.cos_phase[15]}}, r_in.cos_phase};
    assign w_s34 = {{18{r_in.sin_phase[15]}}, r_in.sin_phase};
    assign w_2c  = {{17{r_in.cos_phase[15]}}, r_in.cos_phase, 1'b0};
    assign w_ns  = -w_s34;
    assign w_qr  = {3'b000, r_q} - {3'b000, r_r};

    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            ST_MUU: begin w_op_a = {3'b000, r_bu}; w_op_b = {3'b000, r_bu}; end
            ST_MWW: begin w_op_a = {3'b000, r_bw}; w_op_b = {3'b000, r_bw}; end
            ST_MUW: begin w_op_a = {3'b000, r_bu}; w_op_b = {3'b000, r_bw}; end
            ST_SUM: begin
                w_op_a = {{2{r_slope[31]}}, r_slope};
                w_op_b = {{2{r_in.x_position[31]}}, r_in.x_position};
            end
            ST_M1:  begin w_op_a = w_c34; w_op_b = {3'b000, r_r}; end
            ST_M2:  begin w_op_a = w_s34; w_op_b = r_t; end
            ST_M3:  begin w_op_a = w_c34; w_op_b = r_t; end
            ST_M4:  begin w_op_a = w_ns;  w_op_b = {3'b000, r_r}; end
            ST_M5:  begin w_op_a = w_2c;  w_op_b = r_t; end
            ST_M6:  begin w_op_a = w_s34; w_op_b = w_qr; end
            ST_M7:  begin w_op_a = {{2{r_in.amplitude[31]}}, r_in.amplitude}; w_op_b = r_a; end
            ST_M8:  begin w_op_a = {{2{r_in.amplitude[31]}}, r_in.amplitude}; w_op_b = r_b; end
            ST_M9:  begin w_op_a = {3'b000, r_r}; w_op_b = r_g; end
            ST_M10: begin w_op_a = r_t; w_op_b = r_g; end
            ST_M11: begin w_op_a = {{2{r_in.amplitude[31]}}, r_in.amplitude}; w_op_b = r_rg; end
            ST_M12: begin w_op_a = {{2{r_in.amplitude[31]}}, r_in.amplitude}; w_op_b = r_tg; end
            default: begin w_op_a = '0; w_op_b = '0; end
        endcase
    end

    assign w_mul    = w_op_a * w_op_b;
    assign w_pair   = r_acc + r_prod;
    assign w_pair15 = w_pair >>> 15;
    assign w_pair16 = w_pair >>> 16;
    assign w_p29    = r_prod >>> 29;
    assign w_pf     = r_prod >>> P_FRACTION_BITS;
    assign w_bsum   = {{2{w_pf[67]}}, w_pf} + {{38{r_offset[31]}}, r_offset};
    assign w_rsum   = {{22{r_sum[47]}}, r_sum} + {{30{r_yl[39]}}, r_yl};
    assign w_mag    = r_prod[67] ? 64'(-r_prod) : r_prod[63:0];
    assign w_qs     = r_neg ? -{6'b000000, r_quo} : {6'b000000, r_quo};
    assign w_a_sh   = r_a >>> L_SH_A;

    // restoring divide step
    assign w_rem2  = {r_rem, r_dvd[63]};
    assign w_ge    = (w_rem2 >= {1'b0, r_den});
    assign w_ratio = r_full ? 31'h4000_0000 : {1'b0, r_quo[29:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_offset    <= '0;
            r_slope     <= '0;
            r_sum       <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == C_REG_OFFSET) begin
                    r_offset <= i_cfg_data;
                end else if (i_cfg_index == C_REG_SLOPE) begin
                    r_slope <= i_cfg_data;
                end
            end
            if (r_out_valid && i_ready && (r_state != ST_DW)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_in    <= i_in;
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_w     <= w_wc;
                    r_uneg  <= w_u[33];
                    r_bu    <= 31'(w_um >> w_k);
                    r_bw    <= w_wc >> w_k;
                    r_state <= ST_MUU;
                end
                ST_MUU: begin
                    r_prod  <= w_mul;
                    r_state <= ST_MWW;
                end
                ST_MWW: begin
                    r_uu    <= r_prod[61:0];
                    r_prod  <= w_mul;
                    r_state <= ST_MUW;
                end
                ST_MUW: begin
                    r_ww    <= r_prod[61:0];
                    r_prod  <= w_mul;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_uw    <= r_prod[61:0];
                    r_s     <= {2'b00, r_uu} + {2'b00, r_ww};
                    r_prod  <= w_mul;
                    r_state <= ST_BASE;
                end
                ST_BASE: begin
                    if (!r_open) begin
                        r_sum <= sat_48(w_bsum);
                    end
                    r_rem   <= {2'b00, r_ww};
                    r_dvd   <= '0;
                    r_quo   <= '0;
                    r_den   <= r_s;
                    r_full  <= ({2'b00, r_ww} >= r_s);
                    r_cnt   <= 7'd30;
                    r_ret   <= ST_R;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem   <= w_ge ? 64'(w_rem2 - {1'b0, r_den}) : w_rem2[63:0];
                    r_dvd   <= {r_dvd[62:0], 1'b0};
                    r_quo   <= {r_quo[62:0], w_ge};
                    r_cnt   <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= r_ret;
                    end
                end
                ST_R: begin
                    r_r     <= w_ratio;
                    r_rem   <= {2'b00, r_uu};
                    r_dvd   <= '0;
                    r_quo   <= '0;
                    r_full  <= ({2'b00, r_uu} >= r_s);
                    r_cnt   <= 7'd30;
                    r_ret   <= ST_Q;
                    r_state <= ST_DIV;
                end
                ST_Q: begin
                    r_q     <= w_ratio;
                    r_rem   <= {2'b00, r_uw};
                    r_dvd   <= '0;
                    r_quo   <= '0;
                    r_full  <= ({2'b00, r_uw} >= r_s);
                    r_cnt   <= 7'd30;
                    r_ret   <= ST_T;
                    r_state <= ST_DIV;
                end
                ST_T: begin
                    r_t     <= r_uneg ? -{3'b000, w_ratio} : {3'b000, w_ratio};
                    r_state <= ST_M1;
                end
                ST_M1: begin
                    r_prod  <= w_mul;
                    r_state <= ST_M2;
                end
                ST_M2: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= ST_M3;
                end
                ST_M3: begin
                    r_a     <= w_pair15[33:0];
                    r_prod  <= w_mul;
                    r_state <= ST_M4;
                end
                ST_M4: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= ST_M5;
                end
                ST_M5: begin
                    r_b     <= w_pair15[33:0];
                    r_prod  <= w_mul;
                    r_state <= ST_M6;
                end
                ST_M6: begin
                    r_acc   <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= ST_M7;
                end
                ST_M7: begin
                    r_g     <= w_pair16[33:0];
                    r_prod  <= w_mul;
                    r_state <= ST_M8;
                end
                ST_M8: begin
                    r_yl    <= sat_40({{2{w_p29[67]}}, w_p29});
                    r_prod  <= w_mul;
                    r_state <= ST_M9;
                end
                ST_M9: begin
                    r_dp    <= sat_40({{2{w_p29[67]}}, w_p29});
                    r_sum   <= sat_48(w_rsum);
                    r_prod  <= w_mul;
                    r_state <= ST_M10;
                end
                ST_M10: begin
                    r_rg    <= w_p29[33:0];
                    r_prod  <= w_mul;
                    r_state <= ST_M11;
                end
                ST_M11: begin
                    r_tg    <= w_p29[33:0];
                    r_prod  <= w_mul;
                    r_state <= ST_M12;
                end
                ST_M12: begin
                    r_rem   <= '0;
                    r_dvd   <= w_mag;
                    r_quo   <= '0;
                    r_neg   <= r_prod[67];
                    r_den   <= 64'({33'd0, r_w} << L_SH_C);
                    r_cnt   <= 7'd64;
                    r_prod  <= w_mul;
                    r_ret   <= ST_DC;
                    r_state <= ST_DIV;
                end
                ST_DC: begin
                    r_dc    <= sat_40(w_qs);
                    r_rem   <= '0;
                    r_dvd   <= w_mag;
                    r_quo   <= '0;
                    r_neg   <= r_prod[67];
                    r_den   <= 64'({33'd0, r_w} << L_SH_W);
                    r_cnt   <= 7'd64;
                    r_ret   <= ST_DW;
                    r_state <= ST_DIV;
                end
                ST_DW: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.line_value  <= r_yl;
                        r_out.d_amplitude <= sat_40({{36{w_a_sh[33]}}, w_a_sh});
                        r_out.d_center    <= r_dc;
                        r_out.d_width     <= sat_40(w_qs);
                        r_out.d_phase     <= r_dp;
                        r_out.total_value <= r_in.last_line ? r_sum : 48'sd0;
                        r_out.point_done  <= r_in.last_line;
                        r_out_valid       <= 1'b1;
                        r_open            <= !r_in.last_line;
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
